FILE: hdl/icz_pkg.sv
`timescale 1ns / 1ps
package icz_pkg;

  localparam int KMAX            = 5;
  localparam int COEF_W          = 12;
  localparam int SAMPLE_W        = 16;
  localparam int RESULT_W        = 32;
  localparam int PROD_W          = 28;
  localparam int REG_W           = 64;
  localparam int KROW_W          = 60;
  localparam int WIDTH_REG_W     = 11;
  localparam int HEIGHT_W        = 16;
  localparam int BANK_W          = 3;
  localparam int ADDR_W          = 6;
  localparam int QDEPTH          = 4;
  localparam int KERNEL_SIZE_DEF = 3;
  localparam int MAX_WIDTH_DEF   = 1024;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KROW0  = 3'd2,
    REG_KROW1  = 3'd3,
    REG_KROW2  = 3'd4,
    REG_KROW3  = 3'd5,
    REG_KROW4  = 3'd6
  } reg_idx_t;

  typedef logic [KMAX-1:0][KROW_W-1:0] kern_t;

  // one queued step: line store write, window shift, optional output
  typedef struct packed {
    logic              wr;
    logic              emit;
    logic              last;
    logic              border;
    logic [KMAX-1:0]   row_ok;
    logic [KMAX-1:0]   col_ok;
    logic [BANK_W-1:0] bank;
  } icz_ctrl_t;

endpackage

FILE: hdl/icz_fifo.sv
`timescale 1ns / 1ps
module icz_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end
    end
  end
endmodule

FILE: hdl/icz_front.sv
`timescale 1ns / 1ps
module icz_front #(
  parameter int K         = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_mode,
  input  logic signed [15:0]             in_sample,
  output logic                           in_stall,
  input  logic                           restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
  input  logic [15:0]                    eff_h,
  input  logic                           q_full,
  output logic                           q_push,
  output icz_pkg::icz_ctrl_t             q_ctrl,
  output logic [15:0]                    q_sample,
  output logic [$clog2(MAX_WIDTH)-1:0]   q_col
);
  import icz_pkg::*;

  localparam int H2 = K / 2;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int FW = $clog2(H2*MAX_WIDTH + H2 + 1);
  localparam int RW = HEIGHT_W + 1;

  logic [HEIGHT_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0]       in_col_r, in_col_nxt, out_col_r, out_col_nxt, rd_col_r, rd_col_nxt;
  logic [BANK_W-1:0]   bank_r, bank_nxt;
  logic [FW-1:0]       fill_r, fill_nxt, lag;
  logic                accept, frame_done, wr, emit, last, primed;
  logic [WW-1:0]       in_col_p1, rd_col_p1, out_col_p1;
  logic [RW-1:0]       re;
  logic [WW:0]         ce;

  assign in_stall = q_full;

  always_comb begin
    accept     = in_valid && !q_full;
    frame_done = (in_row_r >= eff_h);
    lag        = FW'(eff_w) * FW'(H2) + FW'(H2);
    primed     = (fill_r >= lag);
    wr         = accept && !in_mode && !frame_done;
    emit       = (wr && primed) || (accept && frame_done);
    last       = (out_row_r == eff_h - 16'd1) && (WW'(out_col_r) == eff_w - WW'(1));
    in_col_p1  = WW'(in_col_r) + WW'(1);
    rd_col_p1  = WW'(rd_col_r) + WW'(1);
    out_col_p1 = WW'(out_col_r) + WW'(1);

    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    rd_col_nxt  = rd_col_r;
    bank_nxt    = bank_r;
    fill_nxt    = fill_r;

    if (wr) begin
      if (in_col_p1 >= eff_w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 16'd1;
      end else begin
        in_col_nxt = CW'(in_col_p1);
      end
      if (!primed) begin
        fill_nxt = fill_r + FW'(1);
      end
    end
    // the read column runs ahead of the output by the window lag
    if (wr || emit) begin
      if (rd_col_p1 >= eff_w) begin
        rd_col_nxt = '0;
        bank_nxt   = (bank_r == BANK_W'(K-1)) ? '0 : bank_r + BANK_W'(1);
      end else begin
        rd_col_nxt = CW'(rd_col_p1);
      end
    end
    if (emit) begin
      if (last) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
        rd_col_nxt  = '0;
        bank_nxt    = '0;
        fill_nxt    = '0;
      end else if (out_col_p1 >= eff_w) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 16'd1;
      end else begin
        out_col_nxt = CW'(out_col_p1);
      end
    end
  end

  always_comb begin
    re            = RW'(out_row_r) + RW'(H2);
    ce            = (WW+1)'(out_col_r) + (WW+1)'(H2);
    q_ctrl        = '0;
    q_ctrl.wr     = wr;
    q_ctrl.emit   = emit;
    q_ctrl.last   = last;
    q_ctrl.bank   = bank_r;
    q_ctrl.border = (out_row_r == '0) || (out_col_r == '0) ||
                    (out_row_r == eff_h - 16'd1) || (WW'(out_col_r) == eff_w - WW'(1));
    for (int i = 0; i < K; i++) begin
      q_ctrl.row_ok[i] = (re >= RW'(i)) && ((re - RW'(i)) < RW'(eff_h));
      q_ctrl.col_ok[i] = (ce >= (WW+1)'(i)) && ((ce - (WW+1)'(i)) < (WW+1)'(eff_w));
    end
  end

  assign q_push   = wr || emit;
  assign q_sample = in_sample;
  assign q_col    = rd_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      rd_col_r  <= '0;
      bank_r    <= '0;
      fill_r    <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      rd_col_r  <= rd_col_nxt;
      bank_r    <= bank_nxt;
      fill_r    <= fill_nxt;
    end
  end
endmodule

FILE: hdl/icz_back.sv
`timescale 1ns / 1ps
module icz_back #(
  parameter int K         = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  icz_pkg::icz_ctrl_t           q_ctrl,
  input  logic [15:0]                  q_sample,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  output logic                         q_pop,
  input  icz_pkg::kern_t               kern,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_filtered,
  output logic                         out_frame_last
);
  import icz_pkg::*;

  logic                       adv;
  logic [SAMPLE_W-1:0]        rd_data [K];
  logic                       s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_valid_r;
  icz_ctrl_t                  s1_ctrl_r, s2_ctrl_r, s3_ctrl_r, s4_ctrl_r;
  logic [SAMPLE_W-1:0]        s1_sample_r;
  logic [SAMPLE_W-1:0]        newcol [K];
  logic signed [SAMPLE_W-1:0] win_r [K][K];
  logic signed [COEF_W-1:0]   coef_s [K][K];
  logic signed [PROD_W-1:0]   prod_r [K][K];
  logic signed [RESULT_W-1:0] rsum_r [K];
  logic signed [RESULT_W-1:0] rsum_nxt [K];
  logic signed [RESULT_W-1:0] total_nxt;
  logic signed [RESULT_W-1:0] filtered_r;
  logic                       last_r;

  assign adv            = !out_valid_r || !out_stall;
  assign q_pop          = adv && !q_empty;
  assign out_valid      = out_valid_r;
  assign out_filtered   = filtered_r;
  assign out_frame_last = last_r;

  for (genvar b = 0; b < K; b++) begin : g_bank
    logic [SAMPLE_W-1:0] mem [MAX_WIDTH];
    logic [SAMPLE_W-1:0] rdq_r;
    always_ff @(posedge clk) begin
      if (q_pop && q_ctrl.wr && (q_ctrl.bank == BANK_W'(b))) begin
        mem[q_col] <= q_sample;
      end
      if (adv) begin
        rdq_r <= mem[q_col];
      end
    end
    assign rd_data[b] = rdq_r;
  end

  // newest row comes straight from the sample; older rows rotate out of the banks
  always_comb begin
    for (int i = 0; i < K; i++) begin
      newcol[i] = '0;
    end
    newcol[0] = s1_ctrl_r.wr ? s1_sample_r : '0;
    for (int i = 1; i < K; i++) begin
      for (int b = 0; b < K; b++) begin
        if ((BANK_W+1)'(s1_ctrl_r.bank) + (BANK_W+1)'(K - i) == (BANK_W+1)'(b) ||
            (BANK_W+1)'(s1_ctrl_r.bank) + (BANK_W+1)'(K - i) == (BANK_W+1)'(b + K)) begin
          newcol[i] = rd_data[b];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        coef_s[i][j] = kern[i][COEF_W*j +: COEF_W];
      end
    end
  end

  always_comb begin
    total_nxt = '0;
    for (int i = 0; i < K; i++) begin
      rsum_nxt[i] = '0;
      for (int j = 0; j < K; j++) begin
        rsum_nxt[i] = rsum_nxt[i] + RESULT_W'(prod_r[i][j]);
      end
      total_nxt = total_nxt + rsum_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= q_pop;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r && s4_ctrl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctrl_r   <= q_ctrl;
      s1_sample_r <= q_sample;
      if (s1_vld_r) begin
        s2_ctrl_r <= s1_ctrl_r;
        for (int i = 0; i < K; i++) begin
          win_r[i][0] <= newcol[i];
          for (int j = 1; j < K; j++) begin
            win_r[i][j] <= win_r[i][j-1];
          end
        end
      end
      s3_ctrl_r <= s2_ctrl_r;
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          prod_r[i][j] <= (s2_ctrl_r.row_ok[i] && s2_ctrl_r.col_ok[j] && !s2_ctrl_r.border) ?
                          PROD_W'(coef_s[i][j]) * PROD_W'(win_r[i][j]) : '0;
        end
      end
      s4_ctrl_r <= s3_ctrl_r;
      rsum_r    <= rsum_nxt;
      filtered_r <= total_nxt;
      last_r     <= s4_ctrl_r.last;
    end
  end
endmodule

FILE: hdl/image_conv2d_zero_border.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_mode, in_sample
// out      output     out_valid/out_stall out_filtered, out_frame_last
// cfg      input      APB psel/penable    paddr, pwdata, prdata
//
// One item per clock sustained while neither side stalls; the line store banks take
// one write and one read per clock, and the window shifts one column per item.
// A result passes the queue, bank read, window, products, row sums and total stages
// after the transfer that emits it; outputs trail the input by H2*W+H2 samples.
// Reset is synchronous and clears counters and valids; the line store is not cleared.
// out_stall freezes the back pipe; the four-entry queue then fills and raises in_stall.
module image_conv2d_zero_border #(
  parameter int KERNEL_SIZE = icz_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = icz_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic signed [15:0]             in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_filtered,
  output logic                           out_frame_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [icz_pkg::ADDR_W-1:0]     paddr,
  input  logic [icz_pkg::REG_W-1:0]      pwdata,
  output logic [icz_pkg::REG_W-1:0]      prdata,
  output logic                           pready
);
  import icz_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int SW = 14;
  localparam int QW = $bits(icz_ctrl_t) + SAMPLE_W + CW;

  logic [WIDTH_REG_W-1:0] width_r;
  logic [HEIGHT_W-1:0]    height_r;
  kern_t                  kern_r;
  logic                   wr_en, restart;
  reg_idx_t               idx;
  logic [SW-1:0]          wsat;
  logic [WW-1:0]          eff_w;
  logic [HEIGHT_W-1:0]    eff_h;

  logic                   q_push, q_full, q_pop, q_empty;
  icz_ctrl_t              f_ctrl, b_ctrl;
  logic [SAMPLE_W-1:0]    f_sample, b_sample;
  logic [CW-1:0]          f_col, b_col;
  logic [QW-1:0]          q_dout;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign idx     = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign restart = wr_en && (idx == REG_WIDTH || idx == REG_HEIGHT);

  always_comb begin
    wsat = SW'(width_r);
    if (wsat < SW'(3)) begin
      wsat = SW'(3);
    end else if (wsat > SW'(MAX_WIDTH)) begin
      wsat = SW'(MAX_WIDTH);
    end
    eff_w = WW'(wsat);
    eff_h = (height_r < 16'd3) ? 16'd3 : height_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 16'd480;
      kern_r   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  width_r   <= pwdata[WIDTH_REG_W-1:0];
        REG_HEIGHT: height_r  <= pwdata[HEIGHT_W-1:0];
        REG_KROW0:  kern_r[0] <= pwdata[KROW_W-1:0];
        REG_KROW1:  kern_r[1] <= pwdata[KROW_W-1:0];
        REG_KROW2:  kern_r[2] <= pwdata[KROW_W-1:0];
        REG_KROW3:  kern_r[3] <= pwdata[KROW_W-1:0];
        REG_KROW4:  kern_r[4] <= pwdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = REG_W'(width_r);
      REG_HEIGHT: prdata = REG_W'(height_r);
      REG_KROW0:  prdata = REG_W'(kern_r[0]);
      REG_KROW1:  prdata = REG_W'(kern_r[1]);
      REG_KROW2:  prdata = REG_W'(kern_r[2]);
      REG_KROW3:  prdata = REG_W'(kern_r[3]);
      REG_KROW4:  prdata = REG_W'(kern_r[4]);
      default:    prdata = '0;
    endcase
  end

  icz_front #(.K(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_sample(in_sample),
    .in_stall (in_stall),
    .restart  (restart),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ctrl   (f_ctrl),
    .q_sample (f_sample),
    .q_col    (f_col)
  );

  icz_fifo #(.W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  ({f_ctrl, f_sample, f_col}),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign {b_ctrl, b_sample, b_col} = q_dout;

  icz_back #(.K(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_ctrl        (b_ctrl),
    .q_sample      (b_sample),
    .q_col         (b_col),
    .q_pop         (q_pop),
    .kern          (kern_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_filtered  (out_filtered),
    .out_frame_last(out_frame_last)
  );
endmodule

FILE: hdl/icz_checker.sv
`timescale 1ns / 1ps
module icz_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_mode,
  input logic signed [15:0]         in_sample,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [31:0]         out_filtered,
  input logic                       out_frame_last,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [icz_pkg::ADDR_W-1:0] paddr,
  input logic [icz_pkg::REG_W-1:0]  pwdata,
  input logic [icz_pkg::REG_W-1:0]  prdata,
  input logic                       pready
);
  import icz_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_mode) && $stable(in_sample))
    else $error("stalled input changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered) && $stable(out_frame_last))
    else $error("stalled result changed");

  a_height_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[ADDR_W-1:3] == REG_HEIGHT) ##1
    (paddr[ADDR_W-1:3] == REG_HEIGHT) |->
    prdata[HEIGHT_W-1:0] == $past(pwdata[HEIGHT_W-1:0]))
    else $error("height register readback mismatch");

  a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[ADDR_W-1:3] == REG_WIDTH) ##1
    (paddr[ADDR_W-1:3] == REG_WIDTH) |->
    prdata[WIDTH_REG_W-1:0] == $past(pwdata[WIDTH_REG_W-1:0]))
    else $error("width register readback mismatch");
endmodule

bind image_conv2d_zero_border icz_checker u_icz_checker (.*);

FILE: tb/image_conv2d_zero_border_test.sv
`timescale 1ns / 1ps
module image_conv2d_zero_border_test;
  import icz_pkg::*;

  localparam int KSZ   = KERNEL_SIZE_DEF;
  localparam int MAXW  = MAX_WIDTH_DEF;
  localparam int HALF  = KSZ / 2;
  localparam int RING  = KSZ + 1;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] filtered;
    logic               last;
  } pixel_out_t;

  typedef struct {
    logic               mode;
    logic signed [15:0] sample;
    logic               has_res;
    logic               last;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic signed [15:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_filtered;
  logic out_frame_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0] pwdata = '0;
  logic [REG_W-1:0] prdata;
  logic pready;

  // tags travel with each transfer: typed-in expectation for the directed rows
  logic tag_typed = 1'b0;
  logic tag_res = 1'b0;
  logic tag_last = 1'b0;

  int send_pct = 0;
  int recv_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int errors = 0;
  int cycles = 0;
  int items = 0;

  pixel_out_t pixels_due[$];

  // predictor state
  logic [WIDTH_REG_W-1:0] width_reg;
  logic [HEIGHT_W-1:0]    height_reg;
  logic [KROW_W-1:0]      kern_rows[KMAX];
  logic signed [15:0]     rows_seen[RING][MAXW];
  int unsigned            in_r, in_c, out_r, out_c;

  image_conv2d_zero_border i_dut (.*);

  always #5 clk = ~clk;

  function automatic int unsigned eff_w();
    if (width_reg < 3) return 3;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic longint conv_pixel(int unsigned r, int unsigned c,
                                        int unsigned w, int unsigned h);
    longint acc;
    longint rr, cc;
    logic signed [COEF_W-1:0] k;
    acc = 0;
    if (r == 0 || c == 0 || r == h - 1 || c == w - 1) return 0;
    for (int i = 0; i < KSZ; i++)
      for (int j = 0; j < KSZ; j++) begin
        rr = longint'(r) + HALF - i;
        cc = longint'(c) + HALF - j;
        if (rr < 0 || cc < 0 || rr >= h || cc >= w) continue;
        k = kern_rows[i][COEF_W*j +: COEF_W];
        acc += longint'(k) * longint'(rows_seen[rr % RING][cc % MAXW]);
      end
    return acc;
  endfunction

  function automatic void predict_pixel(input logic md, input logic signed [15:0] smp,
                                        output bit emit, output pixel_out_t px);
    int unsigned w, h, lag, recv, done;
    longint acc;
    w = eff_w();
    h = eff_h();
    lag = HALF * w + HALF;
    emit = 0;
    if (!md && in_r < h) begin
      rows_seen[in_r % RING][in_c % MAXW] = smp;
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
      recv = in_r * w + in_c;
      done = out_r * w + out_c;
      emit = (recv >= done + lag + 1);
    end else if (in_r >= h) begin
      emit = 1;
    end
    if (!emit) return;
    acc = conv_pixel(out_r, out_c, w, h);
    px.filtered = acc[31:0];
    px.last = (out_r == h - 1) && (out_c == w - 1);
    if (px.last) begin
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
  endfunction

  always @(posedge clk) begin
    bit emit;
    pixel_out_t px;
    pixel_out_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_pixel(in_mode, in_sample, emit, px);
        if (tag_typed) begin
          px.filtered = '0;
          px.last = tag_last;
          emit = tag_res;
        end
        if (emit) pixels_due.push_back(px);
      end
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: result expected none actual filtered=%0d last=%0b", $time,
                   out_filtered, out_frame_last);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          if (want.filtered !== out_filtered) begin
            $display("%0t: filtered expected %0d actual %0d", $time, want.filtered,
                     out_filtered);
            errors++;
          end
          if (want.last !== out_frame_last) begin
            $display("%0t: frame_last expected %0b actual %0b", $time, want.last,
                     out_frame_last);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  task automatic send(input logic md, input logic signed [15:0] smp,
                      input logic typed = 1'b0, input logic res = 1'b0,
                      input logic lst = 1'b0);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_sample <= smp;
    tag_typed <= typed;
    tag_res <= res;
    tag_last <= lst;
    do @(posedge clk); while (in_stall);
    items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pixels_due.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [REG_W-1:0] val);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        width_reg = val[WIDTH_REG_W-1:0];
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      end
      REG_HEIGHT: begin
        height_reg = val[HEIGHT_W-1:0];
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      end
      default: kern_rows[idx - REG_KROW0] = val[KROW_W-1:0];
    endcase
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_kernel(input int style);
    logic [REG_W-1:0] v;
    for (int i = 0; i < KMAX; i++) begin
      case (style)
        0: for (int j = 0; j < KMAX; j++) v[COEF_W*j +: COEF_W] = 12'h7ff;
        1: for (int j = 0; j < KMAX; j++) v[COEF_W*j +: COEF_W] = 12'h800;
        default: v = {$urandom, $urandom};
      endcase
      v[REG_W-1:KROW_W] = 4'($urandom);
      reg_write(reg_idx_t'(REG_KROW0 + i), v);
    end
  endtask

  task automatic geometry(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  // one whole frame, with stray drains mixed in when noisy, then its drain tail
  task automatic run_frame(input bit noisy, input bit pressure);
    int unsigned w, h, total;
    w = eff_w();
    h = eff_h();
    total = w * h;
    for (int unsigned n = 0; n < total; n++) begin
      if (noisy && n > 0 && $urandom_range(19) == 0) send(1'b1, 16'($urandom));
      if (pressure && n == total / 2) begin
        hold_req = 300;
      end
      if (pressure && n == total / 4) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pixels_due.size() == 0);
      end
      send(1'b0, rand_sample());
    end
    for (int unsigned n = 0; n < HALF * w + HALF; n++)
      send(noisy && $urandom_range(9) == 0 ? 1'b0 : 1'b1, 16'($urandom));
  endtask

  task automatic phase(input int spct, input int rpct, input int target,
                       input bit pressure);
    int stop;
    send_pct = spct;
    recv_pct = rpct;
    stop = items + target;
    if (pressure) begin
      geometry(20, 12);
      run_frame(1'b0, 1'b1);
    end
    // abandon a frame part way through
    geometry($urandom_range(12, 3), 65535);
    repeat ($urandom_range(40, 10)) send(1'b0, rand_sample());
    while (items < stop) begin
      if ($urandom_range(3) == 0) load_kernel($urandom_range(5));
      geometry($urandom_range(9) == 0 ? $urandom_range(40, 3) : $urandom_range(10, 3),
               $urandom_range(6, 3));
      repeat ($urandom_range(3, 1)) run_frame(1'b1, 1'b0);
    end
  endtask

  initial begin
    dir_row_t dir_rows[$];
    width_reg = 11'd1024;
    height_reg = 16'd480;
    foreach (kern_rows[i]) kern_rows[i] = '0;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero kernel after reset: every output is zero, last on the ninth
    dir_rows = '{
      '{1'b1, 16'sh1234, 1'b0, 1'b0},  // drain before the frame is in
      '{1'b0, 16'sh7fff, 1'b0, 1'b0},
      '{1'b0, 16'sh8000, 1'b0, 1'b0},
      '{1'b0, 16'sh0000, 1'b0, 1'b0},
      '{1'b0, 16'sh0001, 1'b0, 1'b0},
      '{1'b0, 16'shffff, 1'b1, 1'b0},
      '{1'b0, 16'sh5555, 1'b1, 1'b0},
      '{1'b0, 16'shaaaa, 1'b1, 1'b0},
      '{1'b0, 16'sh7fff, 1'b1, 1'b0},
      '{1'b0, 16'sh8000, 1'b1, 1'b0},
      '{1'b0, 16'sh4321, 1'b1, 1'b0},  // sample after the frame acts as drain
      '{1'b1, 16'sh0000, 1'b1, 1'b0},
      '{1'b1, 16'sh0000, 1'b1, 1'b0},
      '{1'b1, 16'sh0000, 1'b1, 1'b1}
    };
    geometry(3, 3);
    foreach (dir_rows[i])
      send(dir_rows[i].mode, dir_rows[i].sample, 1'b1, dir_rows[i].has_res,
           dir_rows[i].last);

    // extreme kernels and geometry, checked by the predictor
    load_kernel(0);
    geometry(0, 0);
    run_frame(1'b0, 1'b0);
    load_kernel(1);
    geometry(5, 4);
    run_frame(1'b0, 1'b0);
    // width clamps to MAXW; results start after a full line plus one sample
    geometry(2047, 3);
    repeat (1060) send(1'b0, rand_sample());
    load_kernel(2);

    phase(34, 54, 200, 1'b0);
    phase(54, 34, 200, 1'b0);
    phase(0, 0, 150, 1'b1);

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/icz_pkg.sv
hdl/icz_fifo.sv
hdl/icz_front.sv
hdl/icz_back.sv
hdl/image_conv2d_zero_border.sv
hdl/icz_checker.sv
tb/image_conv2d_zero_border_test.sv
